>>> rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants and helpers for the great-circle distance core.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int RAD_W = 16;
	localparam int DIST_W = 18;
	// angle inputs in units of 1/2^ANGLE_FRAC_BITS degree
	localparam int ANGLE_FRAC_BITS = 16;
	// angles are radians in Q30; cordic datapath words
	localparam int ANG_W = 34;
	localparam int VEC_W = 36;

	localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
	localparam logic signed [ANG_W-1:0] PI_Q30 = ANG_W'(signed'((PI60 + (64'd1 << 29)) >> 30));
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 =
		ANG_W'(signed'((PI60 + (64'd1 << 30)) >> 31));
	localparam logic [63:0] K36 = (PI60 + 64'd180 * (64'd1 << 23)) / (64'd180 * (64'd1 << 24));
	localparam logic signed [VEC_W-1:0] GAIN_Q30 = VEC_W'(36'sh026DD3B6A);
	localparam logic signed [VEC_W-1:0] ONE_Q30 = VEC_W'(36'sd1 << 30);
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// atan(2^-i) in Q30 by power series in Q62
	function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] part;
		int k;
		term = 64'd0;
		sum = 64'd0;
		part = 64'd0;
		k = 0;
		if (i == 0) begin
			return ANG_W'(PI60 >> 32);
		end
		if (i > 62) begin
			return '0;
		end
		term = 64'd1 << (62 - i);
		while (term != 64'd0) begin
			part = term / 64'(2 * k + 1);
			if (k % 2 == 1) begin
				sum = sum - part;
			end else begin
				sum = sum + part;
			end
			k = k + 1;
			term = (2 * i >= 63) ? 64'd0 : (term >> (2 * i));
		end
		return ANG_W'((sum + (64'd1 << 31)) >> 32);
	endfunction

	typedef struct packed {
		logic signed [VEC_W-1:0] s1;
		logic signed [VEC_W-1:0] c1;
		logic signed [VEC_W-1:0] s2;
		logic signed [VEC_W-1:0] c2;
		logic signed [VEC_W-1:0] cd;
	} trig_t;

endpackage

>>> rtl/core/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One registered cordic rotation step (sine and cosine).
// ----------------------------------------------------------------------------
module gcd_rot_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [gcd_pkg::VEC_W-1:0] x_in,
	input  logic signed [gcd_pkg::VEC_W-1:0] y_in,
	input  logic signed [gcd_pkg::ANG_W-1:0] z_in,
	output logic signed [gcd_pkg::VEC_W-1:0] x_q,
	output logic signed [gcd_pkg::VEC_W-1:0] y_q,
	output logic signed [gcd_pkg::ANG_W-1:0] z_q
);
	import gcd_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in >= 0) begin
				x_q <= x_in - (y_in >>> STEP);
				y_q <= y_in + (x_in >>> STEP);
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + (y_in >>> STEP);
				y_q <= y_in - (x_in >>> STEP);
				z_q <= z_in + ATAN;
			end
		end
	end
endmodule

>>> rtl/core/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One registered cordic vectoring step (arc cosine).
// ----------------------------------------------------------------------------
module gcd_vec_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [gcd_pkg::VEC_W-1:0] x_in,
	input  logic signed [gcd_pkg::VEC_W-1:0] y_in,
	input  logic signed [gcd_pkg::ANG_W-1:0] z_in,
	output logic signed [gcd_pkg::VEC_W-1:0] x_q,
	output logic signed [gcd_pkg::VEC_W-1:0] y_q,
	output logic signed [gcd_pkg::ANG_W-1:0] z_q
);
	import gcd_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in >= 0) begin
				x_q <= x_in + (y_in >>> STEP);
				y_q <= y_in - (x_in >>> STEP);
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - (y_in >>> STEP);
				y_q <= y_in + (x_in >>> STEP);
				z_q <= z_in - ATAN;
			end
		end
	end
endmodule

>>> rtl/core/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One or two registered bit steps of the integer square root, with pass-along data.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [61:0] rem_in,
	input  logic [61:0] root_in,
	input  logic signed [gcd_pkg::VEC_W-1:0] c_in,
	output logic [61:0] rem_q,
	output logic [61:0] root_q,
	output logic signed [gcd_pkg::VEC_W-1:0] c_q
);
	import gcd_pkg::*;

	localparam int B0 = 60 - 4 * STEP;
	localparam int B1 = B0 - 2;

	logic [61:0] r0;
	logic [61:0] n0;
	logic [61:0] r1;
	logic [61:0] n1;

	always_comb begin
		if (rem_in >= root_in + (62'd1 << B0)) begin
			n0 = rem_in - (root_in + (62'd1 << B0));
			r0 = (root_in >> 1) + (62'd1 << B0);
		end else begin
			n0 = rem_in;
			r0 = root_in >> 1;
		end
		if (B1 < 0) begin
			n1 = n0;
			r1 = r0;
		end else if (n0 >= r0 + (62'd1 << B1)) begin
			n1 = n0 - (r0 + (62'd1 << B1));
			r1 = (r0 >> 1) + (62'd1 << B1);
		end else begin
			n1 = n0;
			r1 = r0 >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= n1;
			root_q <= r1;
			c_q <= c_in;
		end
	end
endmodule

>>> rtl/core/great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Spherical law of cosines distance in whole kilometres.
// ----------------------------------------------------------------------------
// Fully pipelined: a new point pair is taken every cycle when the output is
// not stalled. The pipeline is made of the two chains of cordic cells, the
// sixteen square root cells, four angle stages, three product stages, the
// clamp and two multiply stages; a stalled output freezes the whole pipeline.
module great_circle_distance_core #(
	parameter int TRIG_ITERATIONS = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [gcd_pkg::RAD_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [gcd_pkg::LAT_W-1:0] lat_first,
	input  logic signed [gcd_pkg::LON_W-1:0] lon_first,
	input  logic signed [gcd_pkg::LAT_W-1:0] lat_second,
	input  logic signed [gcd_pkg::LON_W-1:0] lon_second,
	output logic out_valid,
	input  logic out_stall,
	output logic [gcd_pkg::DIST_W-1:0] distance_km
);
	import gcd_pkg::*;

	localparam int N = TRIG_ITERATIONS;
	localparam int SQ = 16;
	// capture, reduce, convert, fold, cell chain, products x3, clamp, sqrt, vec, mul, out
	localparam int DEPTH = 4 + N + 4 + SQ + N + 2;
	localparam int FULL = 360 << ANGLE_FRAC_BITS;
	localparam int DW = 26;

	logic [RAD_W-1:0] radius_q;
	logic en;
	logic [DEPTH-1:0] vld_q;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(6378);
			vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
			if (en) begin
				vld_q <= {vld_q[DEPTH-2:0], in_valid};
			end
		end
	end

	// stage 1: angles and the longitude difference
	logic signed [DW-1:0] ang_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= DW'(lat_first);
			ang_s1[1] <= DW'(lat_second);
			ang_s1[2] <= DW'(lon_first) - DW'(lon_second);
		end
	end

	// stage 2: reduce to [-180,180)
	logic signed [DW-1:0] red_s2 [3];
	logic signed [DW-1:0] rem_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ang_s1[k] >= DW'(FULL / 2)) begin
				rem_c[k] = ang_s1[k] - DW'(FULL);
			end else if (ang_s1[k] < -DW'(FULL / 2)) begin
				rem_c[k] = ang_s1[k] + DW'(FULL);
			end else begin
				rem_c[k] = ang_s1[k];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			red_s2 <= rem_c;
		end
	end

	// stage 3: degrees to radians
	logic signed [ANG_W-1:0] rad_s3 [3];
	logic [63:0] mag_c [3];
	logic [63:0] prod_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_c[k] = 64'(red_s2[k] < 0 ? -red_s2[k] : red_s2[k]);
			prod_c[k] = (mag_c[k] * K36 + (64'd1 << (ANGLE_FRAC_BITS + 5)))
				>> (ANGLE_FRAC_BITS + 6);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rad_s3[k] <= red_s2[k] < 0 ? -ANG_W'(prod_c[k]) : ANG_W'(prod_c[k]);
			end
		end
	end

	// stage 4: fold into +-pi/2
	logic signed [ANG_W-1:0] z0_s4 [3];
	logic [2:0] flip_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (rad_s3[k] > HALF_PI_Q30) begin
					z0_s4[k] <= rad_s3[k] - PI_Q30;
					flip_s4[k] <= 1'b1;
				end else if (rad_s3[k] < -HALF_PI_Q30) begin
					z0_s4[k] <= rad_s3[k] + PI_Q30;
					flip_s4[k] <= 1'b1;
				end else begin
					z0_s4[k] <= rad_s3[k];
					flip_s4[k] <= 1'b0;
				end
			end
		end
	end

	// rotation chains
	logic signed [VEC_W-1:0] rx [3][N+1];
	logic signed [VEC_W-1:0] ry [3][N+1];
	logic signed [ANG_W-1:0] rz [3][N+1];
	logic [2:0] flip_q [N+1];
	assign flip_q[0] = flip_s4;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign rx[k][0] = GAIN_Q30;
		assign ry[k][0] = '0;
		assign rz[k][0] = z0_s4[k];
		for (genvar i = 0; i < N; i++) begin : g_cell
			gcd_rot_cell #(.STEP(i)) u_cell (
				.clk(clk), .en(en),
				.x_in(rx[k][i]), .y_in(ry[k][i]), .z_in(rz[k][i]),
				.x_q(rx[k][i+1]), .y_q(ry[k][i+1]), .z_q(rz[k][i+1])
			);
		end
	end
	for (genvar i = 0; i < N; i++) begin : g_flip
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i+1] <= flip_q[i];
			end
		end
	end

	trig_t trig;
	always_comb begin
		trig.s1 = flip_q[N][0] ? -ry[0][N] : ry[0][N];
		trig.c1 = flip_q[N][0] ? -rx[0][N] : rx[0][N];
		trig.s2 = flip_q[N][1] ? -ry[1][N] : ry[1][N];
		trig.c2 = flip_q[N][1] ? -rx[1][N] : rx[1][N];
		trig.cd = flip_q[N][2] ? -rx[2][N] : rx[2][N];
	end

	// products: t = round(c1*c2), then sum
	logic signed [63:0] ss_p1;
	logic signed [VEC_W-1:0] t_p1;
	logic signed [VEC_W-1:0] cd_p1;
	logic signed [63:0] tc_p2;
	logic signed [63:0] ss_p2;
	logic signed [VEC_W-1:0] a_p3;
	logic signed [63:0] sum_c;
	always_comb begin
		sum_c = ss_p2 + tc_p2 + 64'sd536870912;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ss_p1 <= 64'(trig.s1) * 64'(trig.s2);
			t_p1 <= VEC_W'((64'(trig.c1) * 64'(trig.c2) + 64'sd536870912) >>> 30);
			cd_p1 <= trig.cd;
			tc_p2 <= 64'(t_p1) * 64'(cd_p1);
			ss_p2 <= ss_p1;
			a_p3 <= VEC_W'(sum_c >>> 30);
		end
	end

	// clamp and square
	logic signed [VEC_W-1:0] a_s5;
	logic [61:0] sq_c;
	always_ff @(posedge clk) begin
		if (en) begin
			if (a_p3 > ONE_Q30) begin
				a_s5 <= ONE_Q30;
			end else if (a_p3 < -ONE_Q30) begin
				a_s5 <= -ONE_Q30;
			end else begin
				a_s5 <= a_p3;
			end
		end
	end
	assign sq_c = 62'((64'sd1 << 60) - 64'(a_s5) * 64'(a_s5));

	// square root chain
	logic [61:0] srem [SQ+1];
	logic [61:0] sroot [SQ+1];
	logic signed [VEC_W-1:0] sc [SQ+1];
	assign srem[0] = sq_c;
	assign sroot[0] = '0;
	assign sc[0] = a_s5;
	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		gcd_sqrt_cell #(.STEP(i)) u_sq (
			.clk(clk), .en(en),
			.rem_in(srem[i]), .root_in(sroot[i]), .c_in(sc[i]),
			.rem_q(srem[i+1]), .root_q(sroot[i+1]), .c_q(sc[i+1])
		);
	end

	// vectoring chain
	logic signed [VEC_W-1:0] vx [N+1];
	logic signed [VEC_W-1:0] vy [N+1];
	logic signed [ANG_W-1:0] vz [N+1];
	logic signed [VEC_W-1:0] s_root;
	assign s_root = VEC_W'(sroot[SQ]);
	always_comb begin
		if (sc[SQ] < 0) begin
			vx[0] = s_root;
			vy[0] = -sc[SQ];
			vz[0] = HALF_PI_Q30;
		end else begin
			vx[0] = sc[SQ];
			vy[0] = s_root;
			vz[0] = '0;
		end
	end
	for (genvar i = 0; i < N; i++) begin : g_vec
		gcd_vec_cell #(.STEP(i)) u_vec (
			.clk(clk), .en(en),
			.x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
			.x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1])
		);
	end

	// radius scaling
	logic [ANG_W-2:0] zc;
	logic [49:0] dprod_m1;
	logic [63:0] dsum;
	assign zc = vz[N] < 0 ? '0 : (ANG_W-1)'(vz[N]);
	assign dsum = (64'(dprod_m1) + (64'd1 << 29)) >> 30;
	always_ff @(posedge clk) begin
		if (en) begin
			dprod_m1 <= 50'(radius_q) * 50'(zc);
			distance_km <= dsum > 64'(DIST_MAX) ? DIST_MAX : DIST_W'(dsum);
		end
	end

	assign out_valid = vld_q[DEPTH-1];

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_km))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall not tied to output");
	assert property (@(posedge clk) disable iff (!arst_n)
		en && a_s5 >= 0 |-> a_s5 <= ONE_Q30)
		else $error("clamp escaped");
endmodule
